// ----- hdl/smup_pkg.sv -----
`default_nettype none

package smup_pkg;

    // Default receive FIFO depth
    localparam int unsigned SMUP_FIFO_DEPTH = 16;

    // Action codes on the request channel
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_MOTION = 2'd2;

    // Register offsets
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    // Interrupt identification codes
    localparam logic [7:0] IIR_NONE = 8'h01;
    localparam logic [7:0] IIR_THRE = 8'h02;
    localparam logic [7:0] IIR_RX   = 8'h04;

    // Fixed register values and masks
    localparam logic [7:0] LSR_BASE   = 8'h60;
    localparam logic [7:0] MSR_VALUE  = 8'h00;
    localparam logic [7:0] OPEN_BUS   = 8'hff;
    localparam logic [3:0] IER_MASK   = 4'hf;
    localparam logic [7:0] MOUSE_ID   = 8'h4d;  // 'M'

    // Packet header bits
    localparam logic [7:0] HEAD_SYNC  = 8'h40;
    localparam logic [7:0] HEAD_LEFT  = 8'h20;
    localparam logic [7:0] HEAD_RIGHT = 8'h10;
    localparam logic [7:0] HEAD_Y_HI  = 8'h0c;
    localparam logic [7:0] HEAD_X_HI  = 8'h03;
    localparam logic [7:0] LOW_SIX    = 8'h3f;
    localparam logic signed [15:0] MOTION_MAX = 16'sd127;

    // Channel payloads
    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         addr;
        logic [7:0]         write_data;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [1:0]         buttons;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] irq_requests;
    } rsp_t;

    // Classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_POP,
        CMD_READ,
        CMD_TX,
        CMD_IER,
        CMD_DTR,
        CMD_SCR,
        CMD_MOTION
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic [2:0]      addr;
        logic [7:0]      wdata;
        logic [2:0][7:0] pkt;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_PUSH1,
        BK_PUSH2,
        BK_POP
    } bk_state_t;

    // Saturate a motion delta to -127..127, two's complement byte
    function automatic logic [7:0] clamp_motion(input logic signed [15:0] v);
        logic [7:0] r;
        if (v > MOTION_MAX) begin
            r = MOTION_MAX[7:0];
        end else if (v < -MOTION_MAX) begin
            r = 8'(-MOTION_MAX);
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/smup_chan_if.sv -----
`default_nettype none

interface smup_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/smup_ram.sv -----
`default_nettype none

module smup_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ----- hdl/smup_front.sv -----
`default_nettype none

module smup_front (
    input  logic           clk,
    input  logic           rst_n,
    smup_chan_if.sink      item,
    output logic           cmd_valid,
    input  logic           cmd_take,
    output smup_pkg::cmd_t cmd
);
    import smup_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic [7:0] x_b, y_b;
    logic       push, pop;

    // Classify the incoming transfer
    always_comb
    begin
        x_b = clamp_motion(item.payload.dx);
        y_b = clamp_motion(item.payload.dy);
        dec.kind   = CMD_NOP;
        dec.addr   = item.payload.addr;
        dec.wdata  = item.payload.write_data;
        dec.pkt[0] = HEAD_SYNC
                   | (item.payload.buttons[0] ? HEAD_LEFT  : 8'h00)
                   | (item.payload.buttons[1] ? HEAD_RIGHT : 8'h00)
                   | ((y_b >> 4) & HEAD_Y_HI)
                   | ((x_b >> 6) & HEAD_X_HI);
        dec.pkt[1] = x_b & LOW_SIX;
        dec.pkt[2] = y_b & LOW_SIX;
        unique case (item.payload.action)
            ACT_READ:
            begin
                dec.kind = (item.payload.addr == REG_DATA) ? CMD_POP : CMD_READ;
            end
            ACT_WRITE:
            begin
                unique case (item.payload.addr)
                    REG_DATA: dec.kind = CMD_TX;
                    REG_IER:  dec.kind = CMD_IER;
                    REG_MCR:  dec.kind = item.payload.write_data[0] ? CMD_DTR : CMD_NOP;
                    REG_SCR:  dec.kind = CMD_SCR;
                    default:  dec.kind = CMD_NOP;
                endcase
            end
            ACT_MOTION: dec.kind = CMD_MOTION;
            default:    dec.kind = CMD_NOP;
        endcase
    end

    // Two-entry command queue
    assign item.ready = (cnt_reg != 2'd2);
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign cmd        = q_reg[rd_ptr_reg];
    assign push       = item.valid && item.ready;
    assign pop        = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule

`default_nettype wire

// ----- hdl/smup_back.sv -----
`default_nettype none

module smup_back #(
    parameter int unsigned FIFO_DEPTH = smup_pkg::SMUP_FIFO_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_take,
    input  smup_pkg::cmd_t cmd,
    smup_chan_if.source    result
);
    import smup_pkg::*;

    localparam int unsigned AW = $clog2(FIFO_DEPTH);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    bk_state_t   state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]  ie_reg, ie_next;
    logic [7:0]  ident_reg, ident_next;
    logic        rx_ready_reg, rx_ready_next;
    logic [7:0]  scratch_reg, scratch_next;
    logic [7:0]  stale_reg, stale_next;
    logic [1:0]  irq_acc_reg, irq_acc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic [1:0]  irq_out_reg, irq_out_next;

    logic          push_en, push_clear, finish;
    logic [7:0]    push_byte, fin_data, reg_value;
    logic [CW-1:0] push_cnt;
    logic [SW-1:0] wsum;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;

    smup_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_byte),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Write slot: head plus fill count, wrapped once
    always_comb
    begin
        push_cnt = push_clear ? '0 : count_reg;
        wsum     = SW'(head_reg) + SW'(push_cnt);
        if (wsum >= SW'(FIFO_DEPTH))
        begin
            wsum = wsum - SW'(FIFO_DEPTH);
        end
        ram_waddr = wsum[AW-1:0];
    end

    // Plain register reads
    always_comb
    begin
        unique case (cmd_reg.addr)
            REG_IIR: reg_value = ident_reg;
            REG_LSR: reg_value = LSR_BASE | {7'd0, rx_ready_reg};
            REG_MSR: reg_value = MSR_VALUE;
            REG_SCR: reg_value = scratch_reg;
            default: reg_value = OPEN_BUS;
        endcase
    end

    // Sequencer for one command
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ie_next        = ie_reg;
        ident_next     = ident_reg;
        rx_ready_next  = rx_ready_reg;
        scratch_next   = scratch_reg;
        stale_next     = stale_reg;
        irq_acc_next   = irq_acc_reg;
        out_valid_next = out_valid_reg && !result.ready;
        rdata_next     = rdata_reg;
        irq_out_next   = irq_out_reg;
        cmd_take       = 1'b0;
        push_en        = 1'b0;
        push_clear     = 1'b0;
        push_byte      = 8'h00;
        finish         = 1'b0;
        fin_data       = 8'h00;
        ram_we         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (!out_valid_reg || result.ready))
                begin
                    cmd_take   = 1'b1;
                    cmd_next   = cmd;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                irq_acc_next = 2'd0;
                state_next   = BK_IDLE;
                unique case (cmd_reg.kind)
                    CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            finish   = 1'b1;
                            fin_data = stale_reg;
                        end
                        else
                        begin
                            state_next = BK_POP;
                        end
                    end
                    CMD_READ:
                    begin
                        finish   = 1'b1;
                        fin_data = reg_value;
                    end
                    CMD_TX:
                    begin
                        ident_next   = ie_reg[1] ? IIR_THRE : IIR_NONE;
                        irq_acc_next = {1'b0, ie_reg[1]};
                        finish       = 1'b1;
                    end
                    CMD_IER:
                    begin
                        ie_next = cmd_reg.wdata[3:0] & IER_MASK;
                        finish  = 1'b1;
                    end
                    CMD_DTR:
                    begin
                        push_clear    = 1'b1;
                        push_en       = 1'b1;
                        push_byte     = MOUSE_ID;
                        count_next    = '0;
                        rx_ready_next = 1'b0;
                        finish        = 1'b1;
                    end
                    CMD_SCR:
                    begin
                        scratch_next = cmd_reg.wdata;
                        finish       = 1'b1;
                    end
                    CMD_MOTION:
                    begin
                        push_en    = 1'b1;
                        push_byte  = cmd_reg.pkt[0];
                        state_next = BK_PUSH1;
                    end
                    CMD_NOP:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            BK_PUSH1:
            begin
                push_en    = 1'b1;
                push_byte  = cmd_reg.pkt[1];
                state_next = BK_PUSH2;
            end
            BK_PUSH2:
            begin
                push_en    = 1'b1;
                push_byte  = cmd_reg.pkt[2];
                finish     = 1'b1;
                state_next = BK_IDLE;
            end
            BK_POP:
            begin
                // RAM data for the front entry is valid now
                head_next  = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    rx_ready_next = 1'b0;
                    stale_next    = ram_rdata;
                    if (ident_reg == IIR_RX)
                    begin
                        ident_next = IIR_NONE;
                    end
                end
                else
                begin
                    rx_ready_next = 1'b1;
                    if (ie_reg[0])
                    begin
                        ident_next   = IIR_RX;
                        irq_acc_next = irq_acc_reg + 2'd1;
                    end
                end
                finish     = 1'b1;
                fin_data   = ram_rdata;
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // Byte push into the receive FIFO, dropped when full
        if (push_en && (push_cnt < CW'(FIFO_DEPTH)))
        begin
            ram_we        = 1'b1;
            count_next    = push_cnt + 1'b1;
            rx_ready_next = 1'b1;
            if (ie_reg[0])
            begin
                ident_next   = IIR_RX;
                irq_acc_next = irq_acc_next + 2'd1;
            end
        end

        if (finish)
        begin
            out_valid_next = 1'b1;
            rdata_next     = fin_data;
            irq_out_next   = irq_acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            ie_reg        <= 4'd0;
            ident_reg     <= IIR_NONE;
            rx_ready_reg  <= 1'b0;
            scratch_reg   <= 8'h00;
            stale_reg     <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ie_reg        <= ie_next;
            ident_reg     <= ident_next;
            rx_ready_reg  <= rx_ready_next;
            scratch_reg   <= scratch_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        irq_acc_reg <= irq_acc_next;
        rdata_reg   <= rdata_next;
        irq_out_reg <= irq_out_next;
    end

    assign result.valid                = out_valid_reg;
    assign result.payload.read_data    = rdata_reg;
    assign result.payload.irq_requests = irq_out_reg;
endmodule

`default_nettype wire

// ----- hdl/serial_mouse_uart_port.sv -----
// Path: command queue, command register, EXEC state, response register.
// A read of a non-empty FIFO's data register adds POP; motion events add
// PUSH1 and PUSH2, as the FIFO RAM has one write port (one byte a cycle).
// A command is taken only in IDLE with the response register free.
// Reset: asynchronous, active low; FIFO empty, interrupts disabled, IIR 0x01.
`default_nettype none

module serial_mouse_uart_port #(
    parameter int unsigned FIFO_DEPTH = smup_pkg::SMUP_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    smup_chan_if.sink   item,
    smup_chan_if.source result
);
    import smup_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    // Request decode and command queue
    smup_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    // Register file, receive FIFO and response register
    smup_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .result    (result)
    );
endmodule

`default_nettype wire
